[sv/repeated_failure_tracker_core_defines.svh]
// assertion helpers for the tracker controller
`ifndef REPEATED_FAILURE_TRACKER_CORE_DEFINES_SVH
`define REPEATED_FAILURE_TRACKER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RFT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tracker check failed");

// next-cycle implication, checked outside reset
`define RFT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tracker check failed");

`endif

[sv/rft_pkg.sv]
package rft_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;

  localparam int ID_W   = 64;
  localparam int TIME_W = 48;
  localparam int CNT_W  = 16;
  localparam int WIN_W  = 32;
  localparam int RISK_W = 9;
  localparam int CFG_DATA_W = 32;

  localparam logic [RISK_W-1:0] RISK_CRIT = 9'd205;
  localparam logic [RISK_W-1:0] RISK_ERR  = 9'd128;

  localparam logic [1:0] STAT_TIMEOUT    = 2'd1;
  localparam logic [1:0] STAT_VALIDATION = 2'd2;

  localparam logic [1:0] SEV_WARNING  = 2'd0;
  localparam logic [1:0] SEV_ERROR    = 2'd1;
  localparam logic [1:0] SEV_CRITICAL = 2'd2;

  typedef enum logic [2:0] {
    KIND_FAILURE    = 3'd0,
    KIND_ROLLBACK   = 3'd1,
    KIND_HIGH_RISK  = 3'd2,
    KIND_REPEATED   = 3'd3,
    KIND_TIMEOUT    = 3'd4,
    KIND_VALIDATION = 3'd5,
    KIND_SUCCESS    = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_LOG        = 3'd1,
    ACT_ALERT      = 3'd2,
    ACT_QUARANTINE = 3'd3,
    ACT_ROLLBACK   = 3'd4,
    ACT_MANUAL     = 3'd5
  } act_t;

  typedef enum logic [2:0] {
    CFG_MASK   = 3'd0,
    CFG_TRACK  = 3'd1,
    CFG_THRESH = 3'd2,
    CFG_WINDOW = 3'd3,
    CFG_RISK   = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_EVICT,
    S_UPDATE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [CNT_W-1:0]  count;
    logic [TIME_W-1:0] first;
    logic [TIME_W-1:0] last;
  } entry_t;

  typedef struct packed {
    logic load_item;
    logic scan_start;
    logic scan_step;
    logic evict_mode;
    logic do_update;
    logic load_result;
  } cmd_t;

  typedef struct packed {
    logic item_ok;
    logic track;
    logic lk_done;
    logic lk_hit;
    logic ev_done;
    logic full;
    logic out_free;
  } sts_t;

endpackage

[sv/rft_if.sv]
// input item channel
interface rft_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] diag_id;
  logic        succeeded;
  logic        was_rolled_back;
  logic [1:0]  status_kind;
  logic [8:0]  risk;
  logic [47:0] now_ms;
  modport source (output valid, diag_id, succeeded, was_rolled_back, status_kind, risk,
                  now_ms, input ready);
  modport sink (input valid, diag_id, succeeded, was_rolled_back, status_kind, risk,
                now_ms, output ready);
endinterface

// result item channel
interface rft_out_if;
  logic        valid;
  logic        ready;
  logic        notify;
  logic [2:0]  notify_kind;
  logic [2:0]  action;
  logic [1:0]  severity;
  logic [15:0] fail_count;
  modport source (output valid, notify, notify_kind, action, severity, fail_count,
                  input ready);
  modport sink (input valid, notify, notify_kind, action, severity, fail_count,
                output ready);
endinterface

// configuration write channel
interface rft_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[sv/repeated_failure_tracker_core.sv]
// a success goes from accept to the result register; a failure first scans the
//   used entries, and a full table adds a scan of all entries to find one to evict
// one item at a time: the table scans read one entry per cycle, and a new item is
//   taken only in idle, after the last result is loaded into a free output register
// reset: rst is synchronous; it empties the table and loads the register defaults
module repeated_failure_tracker_core (
  input logic clk,
  input logic rst,
  rft_in_if.sink    in_ch,
  rft_out_if.source out_ch,
  rft_cfg_if.sink   cfg
);
  import rft_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign in_ch.ready = in_ready;
  assign cfg.ready   = 1'b1;

  rft_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rft_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .diag_id         (in_ch.diag_id),
    .succeeded       (in_ch.succeeded),
    .was_rolled_back (in_ch.was_rolled_back),
    .status_kind     (in_ch.status_kind),
    .risk            (in_ch.risk),
    .now_ms          (in_ch.now_ms),
    .cfg_we          (cfg.valid),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .notify          (out_ch.notify),
    .notify_kind     (out_ch.notify_kind),
    .action          (out_ch.action),
    .severity        (out_ch.severity),
    .fail_count      (out_ch.fail_count)
  );

endmodule

[sv/rft_ctrl.sv]
`include "repeated_failure_tracker_core_defines.svh"

module rft_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rft_pkg::sts_t sts,
  output rft_pkg::cmd_t cmd
);
  import rft_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_LOOKUP;
      end
      S_LOOKUP: begin
        if (sts.item_ok) begin
          state_next = S_FINISH;
        end else if (sts.lk_done) begin
          if (!sts.track) state_next = S_FINISH;
          else if (sts.lk_hit || !sts.full) state_next = S_UPDATE;
          else state_next = S_EVICT;
        end
      end
      S_EVICT: begin
        if (sts.ev_done) state_next = S_UPDATE;
      end
      S_UPDATE: state_next = S_FINISH;
      S_FINISH: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load_item = in_valid;
        cmd.scan_start = in_valid;
      end
      S_LOOKUP: begin
        cmd.scan_step = 1'b1;
        if (!sts.item_ok && sts.lk_done && sts.track && !sts.lk_hit && sts.full) begin
          cmd.scan_start = 1'b1;
          cmd.evict_mode = 1'b1;
        end
      end
      S_EVICT: begin
        cmd.scan_step = 1'b1;
        cmd.evict_mode = 1'b1;
      end
      S_UPDATE: cmd.do_update = 1'b1;
      S_FINISH: cmd.load_result = sts.out_free;
      default: cmd = '0;
    endcase
  end

  `RFT_ASSERT_NEXT(a_update_then_finish, state == S_UPDATE, state == S_FINISH)
  `RFT_ASSERT_NOW(a_result_needs_room, cmd.load_result, sts.out_free)
  `RFT_ASSERT_NOW(a_evict_only_full, state == S_EVICT, sts.full && sts.track)

endmodule

[sv/rft_dp.sv]
module rft_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  rft_pkg::cmd_t                cmd,
  output rft_pkg::sts_t                sts,
  // item payload
  input  logic [rft_pkg::ID_W-1:0]     diag_id,
  input  logic                         succeeded,
  input  logic                         was_rolled_back,
  input  logic [1:0]                   status_kind,
  input  logic [rft_pkg::RISK_W-1:0]   risk,
  input  logic [rft_pkg::TIME_W-1:0]   now_ms,
  // configuration writes
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [rft_pkg::CFG_DATA_W-1:0] cfg_data,
  // result
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         notify,
  output logic [2:0]                   notify_kind,
  output logic [2:0]                   action,
  output logic [1:0]                   severity,
  output logic [rft_pkg::CNT_W-1:0]    fail_count
);
  import rft_pkg::*;

  // configuration registers
  logic [4:0]        mask_r;
  logic              track_r;
  logic [CNT_W-1:0]  thresh_r;
  logic [WIN_W-1:0]  window_r;
  logic [RISK_W-1:0] hrisk_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_r   <= 5'd15;
      track_r  <= 1'b1;
      thresh_r <= 16'd3;
      window_r <= 32'd300000;
      hrisk_r  <= 9'd128;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MASK:   mask_r   <= cfg_data[4:0];
        CFG_TRACK:  track_r  <= cfg_data[0];
        CFG_THRESH: thresh_r <= cfg_data[CNT_W-1:0];
        CFG_WINDOW: window_r <= cfg_data[WIN_W-1:0];
        CFG_RISK:   hrisk_r  <= cfg_data[RISK_W-1:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic [ID_W-1:0]   id_r;
  logic              ok_r, rb_r;
  logic [1:0]        st_r;
  logic [RISK_W-1:0] risk_r;
  logic [TIME_W-1:0] now_r;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      id_r   <= diag_id;
      ok_r   <= succeeded;
      rb_r   <= was_rolled_back;
      st_r   <= status_kind;
      risk_r <= risk;
      now_r  <= now_ms;
    end
  end

  // entry table with registered read
  entry_t mem [TABLE_DEPTH];
  entry_t mem_q;
  logic [CW-1:0] scan_idx;
  logic [AW-1:0] q_idx;
  logic          q_vld;
  logic [CW-1:0] used;
  logic [CW-1:0] limit;
  logic          issue;
  logic          match;
  logic          hit_r;
  logic [AW-1:0] hit_slot;
  entry_t        ent_r;
  logic [TIME_W-1:0] min_val;
  logic [AW-1:0] min_slot;
  logic [CNT_W-1:0] count_r;

  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  assign limit = cmd.evict_mode ? DEPTH_C : used;
  assign issue = cmd.scan_step && !cmd.scan_start && (scan_idx < limit);
  assign match = q_vld && !cmd.evict_mode && (mem_q.id == id_r);

  // update arithmetic
  logic              full;
  logic              expired;
  logic              keep;
  logic [TIME_W-1:0] age;
  logic [CNT_W-1:0]  base_cnt, new_cnt;
  logic [TIME_W-1:0] new_first;
  logic [AW-1:0]     wr_slot;

  assign full      = (used == DEPTH_C);
  assign age       = now_r - ent_r.first;
  assign expired   = (now_r < ent_r.first) || (age > TIME_W'(window_r));
  assign keep      = hit_r && !expired;
  assign base_cnt  = keep ? ent_r.count : '0;
  assign new_first = keep ? ent_r.first : now_r;
  assign new_cnt   = (base_cnt == '1) ? base_cnt : base_cnt + 1'b1;
  assign wr_slot   = hit_r ? hit_slot : (full ? min_slot : used[AW-1:0]);

  // table access and scan
  always_ff @(posedge clk) begin
    mem_q <= mem[scan_idx[AW-1:0]];
    q_idx <= scan_idx[AW-1:0];
    if (cmd.do_update) begin
      mem[wr_slot] <= '{id: id_r, count: new_cnt, first: new_first, last: now_r};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used     <= '0;
      scan_idx <= '0;
      q_vld    <= 1'b0;
      hit_r    <= 1'b0;
    end else begin
      q_vld <= issue;
      if (cmd.scan_start) begin
        scan_idx <= '0;
        if (!cmd.evict_mode) hit_r <= 1'b0;
      end else if (issue) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (match) hit_r <= 1'b1;
      if (cmd.do_update && !hit_r && !full) used <= used + 1'b1;
    end
  end

  // hit capture, oldest search, count
  always_ff @(posedge clk) begin
    if (match) begin
      ent_r    <= mem_q;
      hit_slot <= q_idx;
    end
    if (q_vld && cmd.evict_mode && ((q_idx == '0) || (mem_q.last < min_val))) begin
      min_val  <= mem_q.last;
      min_slot <= q_idx;
    end
    if (cmd.do_update) count_r <= new_cnt;
  end

  // status to controller
  always_comb begin
    sts.item_ok  = ok_r;
    sts.track    = track_r;
    sts.lk_hit   = match;
    sts.lk_done  = match || (!q_vld && (scan_idx >= used));
    sts.ev_done  = !q_vld && (scan_idx == DEPTH_C);
    sts.full     = full;
    sts.out_free = !out_valid || out_ready;
  end

  // result classification
  logic             tracked;
  logic             res_notify;
  kind_t            res_kind;
  act_t             res_act;
  logic [1:0]       res_sev;
  logic [CNT_W-1:0] seen;
  logic             base_notify;

  assign tracked = !ok_r && track_r;

  always_comb begin
    priority if (ok_r) begin
      res_kind = KIND_SUCCESS;    base_notify = mask_r[4];
    end else if (rb_r) begin
      res_kind = KIND_ROLLBACK;   base_notify = mask_r[1];
    end else if (st_r == STAT_TIMEOUT) begin
      res_kind = KIND_TIMEOUT;    base_notify = mask_r[3];
    end else if (st_r == STAT_VALIDATION) begin
      res_kind = KIND_VALIDATION; base_notify = mask_r[0];
    end else if (risk_r >= hrisk_r) begin
      res_kind = KIND_HIGH_RISK;  base_notify = mask_r[2];
    end else begin
      res_kind = KIND_FAILURE;    base_notify = mask_r[0];
    end
    res_notify = base_notify;
    if (tracked && (count_r >= thresh_r)) begin
      res_kind   = KIND_REPEATED;
      res_notify = 1'b1;
    end
    if (tracked) seen = count_r;
    else if (hit_r) seen = ent_r.count;
    else seen = CNT_W'(1);
    res_act = ACT_NONE;
    res_sev = SEV_WARNING;
    if (res_notify) begin
      if (!ok_r) begin
        priority if (seen >= thresh_r) res_act = (risk_r >= RISK_CRIT) ? ACT_QUARANTINE
                                                                          : ACT_MANUAL;
        else if (risk_r >= RISK_CRIT) res_act = ACT_ALERT;
        else if (rb_r) res_act = ACT_ROLLBACK;
        else if (st_r == STAT_TIMEOUT) res_act = ACT_ALERT;
        else if (risk_r >= hrisk_r) res_act = ACT_ALERT;
        else res_act = ACT_LOG;
      end
      if (risk_r >= RISK_CRIT) res_sev = SEV_CRITICAL;
      else if (risk_r >= RISK_ERR) res_sev = SEV_ERROR;
    end else begin
      res_kind = KIND_FAILURE;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      notify      <= res_notify;
      notify_kind <= res_kind;
      action      <= res_act;
      severity    <= res_sev;
      fail_count  <= tracked ? count_r : '0;
    end
  end

endmodule

[dv/rft_scoreboard.sv]
`timescale 1ns / 1ps

// watches the item channels, predicts each result and compares it
module rft_scoreboard (
  input  logic clk,
  input  logic rst,
  rft_in_if    in_ch,
  rft_out_if   out_ch,
  rft_cfg_if   cfg,
  output int   fails,
  output int   pending
);
  import rft_pkg::*;

  typedef struct {
    logic              notify;
    kind_t             kind;
    act_t              act;
    logic [1:0]        sev;
    logic [CNT_W-1:0]  cnt;
  } outcome_t;

  // shadow registers
  logic [4:0]        en_mask;
  logic              trk_en;
  logic [CNT_W-1:0]  thresh;
  logic [WIN_W-1:0]  win;
  logic [RISK_W-1:0] hr_level;

  // shadow tracking table
  int                used;
  logic [ID_W-1:0]   tab_id    [TABLE_DEPTH];
  logic [CNT_W-1:0]  tab_cnt   [TABLE_DEPTH];
  logic [TIME_W-1:0] tab_first [TABLE_DEPTH];
  logic [TIME_W-1:0] tab_last  [TABLE_DEPTH];

  outcome_t outcome_q[$];

  function automatic int find_entry(input logic [ID_W-1:0] id);
    for (int i = 0; i < used; i++) begin
      if (tab_id[i] == id) return i;
    end
    return -1;
  endfunction

  // classify, update the table and work out the outcome of one event
  task automatic predict_event(input logic [ID_W-1:0] id, input logic ok, input logic rb,
                               input logic [1:0] st, input logic [RISK_W-1:0] rk,
                               input logic [TIME_W-1:0] now);
    kind_t             k;
    int                en_bit;
    logic              nt;
    int                hit;
    int                slot;
    logic [CNT_W-1:0]  seen;
    logic [TIME_W-1:0] oldest;
    outcome_t          r;
    r.cnt = '0;
    r.act = ACT_NONE;
    r.sev = SEV_WARNING;
    if (ok) begin
      k = KIND_SUCCESS; en_bit = 4;
    end else if (rb) begin
      k = KIND_ROLLBACK; en_bit = 1;
    end else if (st == STAT_TIMEOUT) begin
      k = KIND_TIMEOUT; en_bit = 3;
    end else if (st == STAT_VALIDATION) begin
      k = KIND_VALIDATION; en_bit = 0;
    end else if (rk >= hr_level) begin
      k = KIND_HIGH_RISK; en_bit = 2;
    end else begin
      k = KIND_FAILURE; en_bit = 0;
    end
    nt = en_mask[en_bit];

    // table update for tracked failures
    if (!ok && trk_en) begin
      hit = find_entry(id);
      if (hit >= 0) begin
        slot = hit;
        // expired window, or time went backwards
        if (now < tab_first[slot] || (now - tab_first[slot]) > {16'd0, win}) begin
          tab_cnt[slot] = '0;
          tab_first[slot] = now;
        end
      end else begin
        if (used >= TABLE_DEPTH) begin
          // evict oldest last time, lowest index on ties
          slot = 0;
          oldest = tab_last[0];
          for (int i = 1; i < TABLE_DEPTH; i++) begin
            if (tab_last[i] < oldest) begin
              oldest = tab_last[i];
              slot = i;
            end
          end
        end else begin
          slot = used;
          used++;
        end
        tab_id[slot] = id;
        tab_cnt[slot] = '0;
        tab_first[slot] = now;
        tab_last[slot] = '0;
      end
      if (tab_cnt[slot] != 16'hFFFF) tab_cnt[slot] = tab_cnt[slot] + 1'b1;
      tab_last[slot] = now;
      r.cnt = tab_cnt[slot];
      if (r.cnt >= thresh) begin
        k = KIND_REPEATED;
        nt = 1'b1;
      end
    end

    // action and severity
    if (nt) begin
      if (!ok) begin
        hit = find_entry(id);
        seen = (hit >= 0) ? tab_cnt[hit] : 16'd1;
        if (seen >= thresh) r.act = (rk >= RISK_CRIT) ? ACT_QUARANTINE : ACT_MANUAL;
        else if (rk >= RISK_CRIT) r.act = ACT_ALERT;
        else if (rb) r.act = ACT_ROLLBACK;
        else if (st == STAT_TIMEOUT) r.act = ACT_ALERT;
        else if (rk >= hr_level) r.act = ACT_ALERT;
        else r.act = ACT_LOG;
      end
      if (rk >= RISK_CRIT) r.sev = SEV_CRITICAL;
      else if (rk >= RISK_ERR) r.sev = SEV_ERROR;
    end else begin
      k = KIND_FAILURE;
    end
    r.notify = nt;
    r.kind = k;
    outcome_q.push_back(r);
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      en_mask <= 5'd15;
      trk_en <= 1'b1;
      thresh <= 16'd3;
      win <= 32'd300000;
      hr_level <= 9'd128;
      used = 0;
      outcome_q.delete();
      pending = 0;
    end else begin
      // register writes
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_MASK:   en_mask <= cfg.data[4:0];
          CFG_TRACK:  trk_en <= cfg.data[0];
          CFG_THRESH: thresh <= cfg.data[15:0];
          CFG_WINDOW: win <= cfg.data;
          CFG_RISK:   hr_level <= cfg.data[8:0];
          default: ;
        endcase
      end
      // accepted input item
      if (in_ch.valid && in_ch.ready)
        predict_event(in_ch.diag_id, in_ch.succeeded, in_ch.was_rolled_back,
                      in_ch.status_kind, in_ch.risk, in_ch.now_ms);
      // accepted result item
      if (out_ch.valid && out_ch.ready) begin
        if (outcome_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result item at %0t", $realtime);
        end else begin
          want = outcome_q.pop_front();
          if (out_ch.notify !== want.notify || out_ch.notify_kind !== want.kind ||
              out_ch.action !== want.act || out_ch.severity !== want.sev ||
              out_ch.fail_count !== want.cnt) begin
            fails++;
            if (fails <= 10)
              $display({"mismatch at %0t: exp n=%0d k=%0d a=%0d s=%0d c=%0d",
                        " got n=%0d k=%0d a=%0d s=%0d c=%0d"},
                       $realtime, want.notify, want.kind, want.act, want.sev, want.cnt,
                       out_ch.notify, out_ch.notify_kind, out_ch.action, out_ch.severity,
                       out_ch.fail_count);
          end
        end
      end
      pending = outcome_q.size();
    end
  end

  initial begin
    fails = 0;
    pending = 0;
  end

endmodule

[dv/repeated_failure_tracker_core_tb.sv]
`timescale 1ns / 1ps

module repeated_failure_tracker_core_tb;
  import rft_pkg::*;

  logic clk = 1'b0;
  logic rst;
  int   fails;
  int   pending;
  bit   calm;
  bit   hold_req;
  int   quiet_cycles;

  logic [TIME_W-1:0] clock_ms;
  logic [ID_W-1:0]   hot_ids  [8];
  logic [ID_W-1:0]   wide_ids [400];

  rft_in_if  in_ch();
  rft_out_if out_ch();
  rft_cfg_if cfg_ch();

  repeated_failure_tracker_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  rft_scoreboard u_scoreboard (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg     (cfg_ch),
    .fails   (fails),
    .pending (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog on cycles with no accepted item or register write
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result receiver with random stalls and one long hold-off
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        hold_req = 1'b0;
        repeat (3000) @(posedge clk);
      end
      out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 11);
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_event(input logic [ID_W-1:0] id, input logic ok, input logic rb,
                            input logic [1:0] st, input logic [RISK_W-1:0] rk,
                            input logic [TIME_W-1:0] now);
    if (!calm && $urandom_range(99) < 11) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 40);
    end
    in_ch.valid <= 1'b1;
    in_ch.diag_id <= id;
    in_ch.succeeded <= ok;
    in_ch.was_rolled_back <= rb;
    in_ch.status_kind <= st;
    in_ch.risk <= rk;
    in_ch.now_ms <= now;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // sender pause until every result is back, then the block's own latency
  task automatic drain;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  function automatic logic [RISK_W-1:0] pick_risk();
    case ($urandom_range(7))
      0: return 9'd0;
      1: return 9'd256;
      2: return 9'd127 + 9'($urandom_range(1));
      3: return 9'd204 + 9'($urandom_range(1));
      default: return 9'($urandom_range(256));
    endcase
  endfunction

  task automatic send_random(input int wide_pct);
    logic [ID_W-1:0] id;
    int sel;
    sel = $urandom_range(99);
    if (sel < wide_pct) id = wide_ids[$urandom_range(399)];
    else if (sel < 92) id = hot_ids[$urandom_range(7)];
    else id = {$urandom, $urandom};
    sel = $urandom_range(99);
    if (sel < 3) clock_ms = clock_ms - 48'($urandom_range(5000));
    else if (sel < 5) clock_ms = 48'({$urandom, $urandom});
    else clock_ms = clock_ms + 48'($urandom_range(40));
    send_event(id, $urandom_range(99) < 15, $urandom_range(99) < 15,
               2'($urandom_range(3)), pick_risk(), clock_ms);
  endtask

  task automatic set_regs;
    logic [31:0] v;
    v = ($urandom_range(3) == 0) ? (($urandom_range(1) != 0) ? 32'd31 : 32'd0)
                                 : 32'($urandom_range(31));
    write_reg(CFG_MASK, v);
    write_reg(CFG_TRACK, 32'($urandom_range(99) < 80));
    case ($urandom_range(6))
      0: v = 32'd0;
      1: v = 32'd1;
      2: v = 32'd2;
      3: v = 32'd65535;
      4: v = 32'($urandom_range(65535));
      default: v = 32'd3;
    endcase
    write_reg(CFG_THRESH, v);
    case ($urandom_range(6))
      0: v = 32'd0;
      1: v = 32'd1;
      2: v = 32'd20;
      3: v = 32'hFFFF_FFFF;
      4: v = $urandom;
      default: v = 32'($urandom_range(200));
    endcase
    write_reg(CFG_WINDOW, v);
    case ($urandom_range(5))
      0: v = 32'd0;
      1: v = 32'd256;
      2: v = 32'd205;
      default: v = 32'($urandom_range(256));
    endcase
    write_reg(CFG_RISK, v);
  endtask

  initial begin
    logic [ID_W-1:0] id_b;
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.diag_id <= '0;
    in_ch.succeeded <= 1'b0;
    in_ch.was_rolled_back <= 1'b0;
    in_ch.status_kind <= '0;
    in_ch.risk <= '0;
    in_ch.now_ms <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_MASK;
    cfg_ch.data <= '0;
    calm = 1'b0;
    hold_req = 1'b0;
    clock_ms = 48'd1000;
    foreach (hot_ids[i]) hot_ids[i] = {$urandom, $urandom};
    foreach (wide_ids[i]) wide_ids[i] = {$urandom, $urandom};
    id_b = hot_ids[0];
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed events under reset defaults
    send_event(64'd1, 1'b1, 1'b0, 2'd0, 9'd0, 48'd10);
    send_event(64'd1, 1'b1, 1'b1, 2'd1, 9'd256, 48'd11);
    send_event(64'd2, 1'b0, 1'b1, 2'd0, 9'd10, 48'd12);
    send_event(64'd3, 1'b0, 1'b0, STAT_TIMEOUT, 9'd50, 48'd13);
    send_event(64'd4, 1'b0, 1'b0, STAT_VALIDATION, 9'd205, 48'd14);
    send_event(64'd5, 1'b0, 1'b0, 2'd3, 9'd0, 48'd15);
    send_event(64'd6, 1'b0, 1'b0, 2'd0, 9'd128, 48'd16);
    send_event(64'd7, 1'b0, 1'b0, 2'd0, 9'd127, 48'd17);
    send_event(64'd0, 1'b0, 1'b0, 2'd0, 9'd256, 48'd0);
    send_event(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 2'd0, 9'd204,
               48'hFFFF_FFFF_FFFF);
    // repeat escalation, then time backwards, then window expiry
    send_event(id_b, 1'b0, 1'b0, 2'd0, 9'd20, 48'd100);
    send_event(id_b, 1'b0, 1'b0, 2'd0, 9'd210, 48'd200);
    send_event(id_b, 1'b0, 1'b0, 2'd0, 9'd20, 48'd300);
    send_event(id_b, 1'b0, 1'b0, 2'd0, 9'd220, 48'd400);
    send_event(id_b, 1'b0, 1'b0, 2'd0, 9'd20, 48'd50);
    send_event(id_b, 1'b0, 1'b0, 2'd0, 9'd20, 48'd300100);
    send_event(id_b, 1'b0, 1'b0, 2'd0, 9'd20, 48'd600200);
    send_event(id_b, 1'b0, 1'b1, 2'd0, 9'd20, 48'd600201);
    drain();

    // tracking off: action still reads the table
    write_reg(CFG_TRACK, 32'd0);
    write_reg(CFG_MASK, 32'd31);
    send_event(id_b, 1'b0, 1'b0, 2'd0, 9'd20, 48'd600300);
    send_event(64'd99, 1'b0, 1'b0, 2'd0, 9'd20, 48'd600301);
    send_event(64'd99, 1'b1, 1'b0, 2'd0, 9'd20, 48'd600302);
    drain();

    // threshold zero with tight window
    write_reg(CFG_TRACK, 32'd1);
    write_reg(CFG_THRESH, 32'd0);
    write_reg(CFG_WINDOW, 32'd0);
    write_reg(CFG_RISK, 32'd0);
    send_event(id_b, 1'b0, 1'b0, 2'd0, 9'd0, 48'd600301);
    send_event(id_b, 1'b0, 1'b0, 2'd0, 9'd0, 48'd600301);
    drain();

    // fill the table past capacity, ties on last time force low-index eviction
    write_reg(CFG_THRESH, 32'd3);
    write_reg(CFG_WINDOW, 32'hFFFF_FFFF);
    write_reg(CFG_RISK, 32'd128);
    write_reg(CFG_MASK, 32'd15);
    calm = 1'b1;
    for (int i = 0; i < 300; i++) begin
      if (i % 40 == 0) clock_ms = clock_ms + 48'd1;
      send_event(wide_ids[i], 1'b0, 1'b0, 2'($urandom_range(3)), pick_risk(), clock_ms);
    end
    calm = 1'b0;
    drain();

    // random phases with varied register settings
    for (int ph = 0; ph < 8; ph++) begin
      set_regs();
      calm = (ph == 2);
      for (int n = 0; n < 100; n++) begin
        if (ph == 3 && n == 10) hold_req = 1'b1;
        send_random((ph % 2 == 0) ? 40 : 10);
      end
      calm = 1'b0;
      drain();
    end

    // restore defaults at the end so reset values are exercised again
    write_reg(CFG_MASK, 32'd15);
    write_reg(CFG_TRACK, 32'd1);
    write_reg(CFG_THRESH, 32'd3);
    write_reg(CFG_WINDOW, 32'd300000);
    write_reg(CFG_RISK, 32'd128);
    for (int n = 0; n < 30; n++) send_random(20);
    drain();

    if (fails == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
